>>> design/stbu_pkg.sv
// shared types and codes for the sorted key table with batched updates
`timescale 1ns / 1ps
package stbu_pkg;

  // request codes (input tuser)
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_MAINT  = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  // result kinds (output tuser)
  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_REMOVED = 3'd1;
  localparam logic [2:0] KIND_INSERT  = 3'd2;
  localparam logic [2:0] KIND_READ    = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_QUEUE,
    S_RD_REQ,
    S_RD_RSP,
    S_RM_INIT,
    S_RM_TAB,
    S_RM_TLAT,
    S_RM_QRD,
    S_RM_QCMP,
    S_RM_DONE,
    S_IN_INIT,
    S_IN_ITEM,
    S_IN_LAT,
    S_IN_DQRD,
    S_IN_DQCMP,
    S_IN_TRD,
    S_IN_TCMP,
    S_IN_DEC,
    S_SH_RD,
    S_SH_CMP,
    S_SH_PUT,
    S_SC_RD,
    S_SC_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [31:0] key;
    logic [31:0] payload;
    logic [4:0]  position;
    logic [5:0]  count;
    logic        last;
  } emit_t;

endpackage

>>> design/sorted_table_batched_update.sv
// sorted key table with queued inserts and removes, merged on a maintenance request
//
//  channel | dir | handshake        | content
//  in_     | in  | tvalid / tready  | tuser: request code, tdata: key, payload, read index
//  out_    | out | tvalid / tready  | tuser: result kind, tdata: status, key, payload,
//          |     |                  | position, entry count; tlast: final beat of a request
//
// one request is worked on at a time; table and both queues sit in single-port-read
// synchronous memories. maintenance walks the table twice against the remove queue,
// then the insert queue against itself and the table, twice if the new keys fit; each
// insert shifts larger table entries up, and a final scan reports positions.
// rst_n (synchronous) clears counts and control; memory contents are left as they are.
// a result waiting on out_tready stalls the work at the point where it is produced;
// a new beat is taken on in_ whenever the engine is idle, even with a result pending.
`timescale 1ns / 1ps
module sorted_table_batched_update #(
  parameter int TABLE_DEPTH        = 32,
  parameter int INSERT_QUEUE_DEPTH = 16,
  parameter int REMOVE_QUEUE_DEPTH = 16,
  parameter int KEY_BITS           = 32,
  parameter int PAYLOAD_BITS       = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // entity_key[31:0], payload_in[63:32], read_index[68:64]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // status[1:0], key_out[33:2], payload_out[65:34],
                                  // position_out[70:66], entry_count[76:71]
  output logic [2:0]  out_tuser,  // result_kind[2:0]
  output logic        out_tlast   // last_result
);
  import stbu_pkg::*;

  localparam int TW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int IQAW  = (INSERT_QUEUE_DEPTH > 1) ? $clog2(INSERT_QUEUE_DEPTH) : 1;
  localparam int IQCW  = $clog2(INSERT_QUEUE_DEPTH + 1);
  localparam int RQAW  = (REMOVE_QUEUE_DEPTH > 1) ? $clog2(REMOVE_QUEUE_DEPTH) : 1;
  localparam int RQCW  = $clog2(REMOVE_QUEUE_DEPTH + 1);
  localparam int LW0   = (CW > IQCW) ? CW : IQCW;
  localparam int LW    = (LW0 > RQCW) ? LW0 : RQCW;
  localparam int TE    = KEY_BITS + PAYLOAD_BITS + 1;  // {new flag, payload, key}
  localparam int QE    = KEY_BITS + PAYLOAD_BITS;

  // memories
  logic [TE-1:0]       tb_mem [TABLE_DEPTH];
  logic [QE-1:0]       iq_mem [INSERT_QUEUE_DEPTH];
  logic [KEY_BITS-1:0] rq_mem [REMOVE_QUEUE_DEPTH];

  logic                tb_we, tb_re;
  logic [TW-1:0]       tb_waddr, tb_raddr;
  logic [TE-1:0]       tb_wdata, tb_rdata_r;
  logic                iq_we, iq_re;
  logic [IQAW-1:0]     iq_waddr, iq_raddr;
  logic [QE-1:0]       iq_rdata_r;
  logic                rq_we, rq_re;
  logic [RQAW-1:0]     rq_waddr, rq_raddr;
  logic [KEY_BITS-1:0] rq_rdata_r;

  // control and working registers
  state_t              state_r, state_nxt;
  logic [CW-1:0]       tcnt_r, tcnt_nxt;
  logic [IQCW-1:0]     iq_cnt_r, iq_cnt_nxt;
  logic [RQCW-1:0]     rq_cnt_r, rq_cnt_nxt;
  logic [LW-1:0]       i_r, i_nxt;
  logic [LW-1:0]       j_r, j_nxt;
  logic [LW-1:0]       w_r, w_nxt;
  logic [LW-1:0]       n_r, n_nxt;        // hits during removal, new keys during merge
  logic [CW-1:0]       rem_cnt_r, rem_cnt_nxt;
  logic                pass_r, pass_nxt;  // 0 counts, 1 acts
  logic                hit_r, hit_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [1:0]          req_r, req_nxt;
  logic [4:0]          idx_r, idx_nxt;
  logic [KEY_BITS-1:0] cur_key_r, cur_key_nxt;
  logic [PAYLOAD_BITS-1:0] cur_pay_r, cur_pay_nxt;

  // output register
  logic                out_valid_r;
  emit_t               out_r;
  emit_t               emit;
  logic                can_emit;

  // unpacked fields of memory read data
  logic [KEY_BITS-1:0]     tb_key;
  logic [PAYLOAD_BITS-1:0] tb_pay;
  logic                    tb_new;
  logic [KEY_BITS-1:0]     iq_key;
  logic [PAYLOAD_BITS-1:0] iq_pay;
  logic                    rd_in_range;
  logic [LW:0]             merged_cnt;

  assign tb_key = tb_rdata_r[KEY_BITS-1:0];
  assign tb_pay = tb_rdata_r[QE-1:KEY_BITS];
  assign tb_new = tb_rdata_r[TE-1];
  assign iq_key = iq_rdata_r[KEY_BITS-1:0];
  assign iq_pay = iq_rdata_r[QE-1:KEY_BITS];

  assign can_emit    = !out_valid_r || out_tready;
  assign in_tready   = (state_r == S_IDLE);
  assign rd_in_range = (32'(idx_r) < 32'(tcnt_r)) && (32'(idx_r) < TABLE_DEPTH);
  assign merged_cnt  = (LW + 1)'(tcnt_r) + (LW + 1)'(n_r);

  // table memory
  always_ff @(posedge clk) begin
    if (tb_we) tb_mem[tb_waddr] <= tb_wdata;
    if (tb_re) tb_rdata_r <= tb_mem[tb_raddr];
  end

  // insert queue memory
  always_ff @(posedge clk) begin
    if (iq_we) iq_mem[iq_waddr] <= {cur_pay_r, cur_key_r};
    if (iq_re) iq_rdata_r <= iq_mem[iq_raddr];
  end

  // remove queue memory
  always_ff @(posedge clk) begin
    if (rq_we) rq_mem[rq_waddr] <= cur_key_r;
    if (rq_re) rq_rdata_r <= rq_mem[rq_raddr];
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tcnt_r   <= '0;
      iq_cnt_r <= '0;
      rq_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      tcnt_r   <= tcnt_nxt;
      iq_cnt_r <= iq_cnt_nxt;
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    w_r       <= w_nxt;
    n_r       <= n_nxt;
    rem_cnt_r <= rem_cnt_nxt;
    pass_r    <= pass_nxt;
    hit_r     <= hit_nxt;
    status_r  <= status_nxt;
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    cur_key_r <= cur_key_nxt;
    cur_pay_r <= cur_pay_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.en) out_r <= emit;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {3'b000, out_r.count, out_r.position, out_r.payload, out_r.key,
                       out_r.status};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    tcnt_nxt    = tcnt_r;
    iq_cnt_nxt  = iq_cnt_r;
    rq_cnt_nxt  = rq_cnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    w_nxt       = w_r;
    n_nxt       = n_r;
    rem_cnt_nxt = rem_cnt_r;
    pass_nxt    = pass_r;
    hit_nxt     = hit_r;
    status_nxt  = status_r;
    req_nxt     = req_r;
    idx_nxt     = idx_r;
    cur_key_nxt = cur_key_r;
    cur_pay_nxt = cur_pay_r;

    tb_we    = 1'b0;
    tb_re    = 1'b0;
    tb_waddr = i_r[TW-1:0];
    tb_raddr = i_r[TW-1:0];
    tb_wdata = {1'b0, cur_pay_r, cur_key_r};
    iq_we    = 1'b0;
    iq_re    = 1'b0;
    iq_waddr = iq_cnt_r[IQAW-1:0];
    iq_raddr = i_r[IQAW-1:0];
    rq_we    = 1'b0;
    rq_re    = 1'b0;
    rq_waddr = rq_cnt_r[RQAW-1:0];
    rq_raddr = j_r[RQAW-1:0];

    emit          = '0;
    emit.count    = 6'(tcnt_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt     = in_tuser;
          cur_key_nxt = KEY_BITS'(in_tdata[31:0]);
          cur_pay_nxt = PAYLOAD_BITS'(in_tdata[63:32]);
          idx_nxt     = in_tdata[68:64];
          unique case (in_tuser)
            REQ_INSERT, REQ_REMOVE: state_nxt = S_QUEUE;
            REQ_MAINT:              state_nxt = S_RM_INIT;
            default:                state_nxt = S_RD_REQ;
          endcase
        end
      end

      S_QUEUE: begin
        if (can_emit) begin
          emit.en   = 1'b1;
          emit.kind = KIND_ACK;
          emit.last = 1'b1;
          if (req_r == REQ_INSERT) begin
            if (iq_cnt_r < IQCW'(INSERT_QUEUE_DEPTH)) begin
              iq_we      = 1'b1;
              iq_cnt_nxt = iq_cnt_r + 1'b1;
            end else begin
              emit.status = ST_FULL;
            end
          end else begin
            if (rq_cnt_r < RQCW'(REMOVE_QUEUE_DEPTH)) begin
              rq_we      = 1'b1;
              rq_cnt_nxt = rq_cnt_r + 1'b1;
            end else begin
              emit.status = ST_FULL;
            end
          end
          state_nxt = S_IDLE;
        end
      end

      S_RD_REQ: begin
        tb_re     = rd_in_range;
        tb_raddr  = TW'(idx_r);
        state_nxt = S_RD_RSP;
      end

      S_RD_RSP: begin
        if (can_emit) begin
          emit.en   = 1'b1;
          emit.kind = KIND_READ;
          emit.last = 1'b1;
          if (rd_in_range) begin
            emit.key      = 32'(tb_key);
            emit.payload  = 32'(tb_pay);
            emit.position = idx_r;
          end else begin
            emit.status = ST_RANGE;
          end
          state_nxt = S_IDLE;
        end
      end

      // removal: pass 0 counts hits, pass 1 reports and compacts
      S_RM_INIT: begin
        i_nxt     = '0;
        n_nxt     = '0;
        w_nxt     = '0;
        pass_nxt  = 1'b0;
        state_nxt = S_RM_TAB;
      end

      S_RM_TAB: begin
        if (i_r == LW'(tcnt_r)) begin
          if (!pass_r) begin
            pass_nxt    = 1'b1;
            i_nxt       = '0;
            rem_cnt_nxt = tcnt_r - n_r[CW-1:0];
          end else begin
            tcnt_nxt  = w_r[CW-1:0];
            state_nxt = S_IN_INIT;
          end
        end else begin
          tb_re     = 1'b1;
          state_nxt = S_RM_TLAT;
        end
      end

      S_RM_TLAT: begin
        cur_key_nxt = tb_key;
        cur_pay_nxt = tb_pay;
        j_nxt       = '0;
        hit_nxt     = 1'b0;
        state_nxt   = S_RM_QRD;
      end

      S_RM_QRD: begin
        if (hit_r || j_r == LW'(rq_cnt_r)) begin
          state_nxt = S_RM_DONE;
        end else begin
          rq_re     = 1'b1;
          state_nxt = S_RM_QCMP;
        end
      end

      S_RM_QCMP: begin
        if (rq_rdata_r == cur_key_r) hit_nxt = 1'b1;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_RM_QRD;
      end

      S_RM_DONE: begin
        if (!pass_r) begin
          if (hit_r) n_nxt = n_r + 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RM_TAB;
        end else if (hit_r) begin
          if (can_emit) begin
            emit.en      = 1'b1;
            emit.kind    = KIND_REMOVED;
            emit.key     = 32'(cur_key_r);
            emit.payload = 32'(cur_pay_r);
            emit.count   = 6'(rem_cnt_r);
            i_nxt        = i_r + 1'b1;
            state_nxt    = S_RM_TAB;
          end
        end else begin
          tb_we     = 1'b1;
          tb_waddr  = w_r[TW-1:0];
          w_nxt     = w_r + 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RM_TAB;
        end
      end

      // merge: pass 0 counts new keys, pass 1 inserts them in place
      S_IN_INIT: begin
        i_nxt      = '0;
        n_nxt      = '0;
        pass_nxt   = 1'b0;
        status_nxt = ST_OK;
        state_nxt  = S_IN_ITEM;
      end

      S_IN_ITEM: begin
        if (i_r == LW'(iq_cnt_r)) begin
          if (pass_r) begin
            i_nxt     = '0;
            state_nxt = S_SC_RD;
          end else if (merged_cnt > (LW + 1)'(TABLE_DEPTH)) begin
            status_nxt = ST_OVERFLOW;
            state_nxt  = S_DONE;
          end else if (n_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            pass_nxt = 1'b1;
            i_nxt    = '0;
          end
        end else begin
          iq_re     = 1'b1;
          state_nxt = S_IN_LAT;
        end
      end

      S_IN_LAT: begin
        cur_key_nxt = iq_key;
        cur_pay_nxt = iq_pay;
        j_nxt       = i_r + 1'b1;
        hit_nxt     = 1'b0;
        state_nxt   = S_IN_DQRD;
      end

      // a later submission of the same key wins
      S_IN_DQRD: begin
        if (hit_r || j_r == LW'(iq_cnt_r)) begin
          j_nxt     = '0;
          state_nxt = S_IN_TRD;
        end else begin
          iq_re     = 1'b1;
          iq_raddr  = j_r[IQAW-1:0];
          state_nxt = S_IN_DQCMP;
        end
      end

      S_IN_DQCMP: begin
        if (iq_key == cur_key_r) hit_nxt = 1'b1;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_IN_DQRD;
      end

      // keys already in the table are dropped
      S_IN_TRD: begin
        if (hit_r || j_r == LW'(tcnt_r)) begin
          state_nxt = S_IN_DEC;
        end else begin
          tb_re     = 1'b1;
          tb_raddr  = j_r[TW-1:0];
          state_nxt = S_IN_TCMP;
        end
      end

      S_IN_TCMP: begin
        if (tb_key == cur_key_r) hit_nxt = 1'b1;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_IN_TRD;
      end

      S_IN_DEC: begin
        if (hit_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_IN_ITEM;
        end else if (!pass_r) begin
          n_nxt     = n_r + 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_IN_ITEM;
        end else begin
          j_nxt     = LW'(tcnt_r);
          state_nxt = S_SH_RD;
        end
      end

      // shift larger keys up by one, from the top down
      S_SH_RD: begin
        if (j_r == '0) begin
          state_nxt = S_SH_PUT;
        end else begin
          tb_re     = 1'b1;
          tb_raddr  = TW'(j_r - 1'b1);
          state_nxt = S_SH_CMP;
        end
      end

      S_SH_CMP: begin
        if (tb_key > cur_key_r) begin
          tb_we     = 1'b1;
          tb_waddr  = j_r[TW-1:0];
          tb_wdata  = tb_rdata_r;
          j_nxt     = j_r - 1'b1;
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_SH_PUT;
        end
      end

      S_SH_PUT: begin
        tb_we     = 1'b1;
        tb_waddr  = j_r[TW-1:0];
        tb_wdata  = {1'b1, cur_pay_r, cur_key_r};
        tcnt_nxt  = tcnt_r + 1'b1;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_IN_ITEM;
      end

      // report positions of new entries in key order, clearing their marks
      S_SC_RD: begin
        if (i_r == LW'(tcnt_r)) begin
          state_nxt = S_DONE;
        end else begin
          tb_re     = 1'b1;
          state_nxt = S_SC_CHK;
        end
      end

      S_SC_CHK: begin
        if (!tb_new) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SC_RD;
        end else if (can_emit) begin
          emit.en       = 1'b1;
          emit.kind     = KIND_INSERT;
          emit.key      = 32'(tb_key);
          emit.payload  = 32'(tb_pay);
          emit.position = 5'(i_r);
          tb_we         = 1'b1;
          tb_wdata      = {1'b0, tb_pay, tb_key};
          i_nxt         = i_r + 1'b1;
          state_nxt     = S_SC_RD;
        end
      end

      S_DONE: begin
        if (can_emit) begin
          emit.en     = 1'b1;
          emit.kind   = KIND_DONE;
          emit.status = status_r;
          emit.last   = 1'b1;
          iq_cnt_nxt  = '0;
          rq_cnt_nxt  = '0;
          state_nxt   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_tcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tcnt_r) <= TABLE_DEPTH)
    else $error("table count beyond depth");

  a_iq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(iq_cnt_r) <= INSERT_QUEUE_DEPTH)
    else $error("insert queue count beyond depth");

  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rq_cnt_r) <= REMOVE_QUEUE_DEPTH)
    else $error("remove queue count beyond depth");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.en && emit.kind == KIND_DONE) |=> (iq_cnt_r == '0 && rq_cnt_r == '0))
    else $error("queues not emptied after maintenance");

  a_no_emit_lost: assert property (@(posedge clk) disable iff (!rst_n)
    emit.en |-> can_emit)
    else $error("result produced while output register is held");
`endif

endmodule

>>> dv/testbench.sv
// self-checking testbench for the sorted key table with batched updates
`timescale 1ns / 1ps
module testbench;
  import stbu_pkg::*;

  localparam int DEPTH      = 32;
  localparam int INS_DEPTH  = 16;
  localparam int REM_DEPTH  = 16;
  localparam int RAND_ITEMS = 450;
  localparam int CYCLE_CAP  = 3000000;

  typedef struct {
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [31:0] key;
    logic [31:0] payload;
    logic [4:0]  position;
    logic [5:0]  count;
    logic        last;
  } table_result_t;

  // keeps its own copy of the table and both queues, predicts every beat on out_
  class table_scoreboard;
    logic [31:0]   tab_key[DEPTH];
    logic [31:0]   tab_pay[DEPTH];
    int            tab_cnt;
    logic [31:0]   ins_key[$];
    logic [31:0]   ins_pay[$];
    logic [31:0]   rem_key[$];
    table_result_t awaited[$];
    int            errors;

    function new();
      tab_cnt = 0;
      errors  = 0;
    endfunction

    function void push(logic [2:0] kind, logic [1:0] st, logic [31:0] k, logic [31:0] p,
                       logic [4:0] pos, int cnt);
      table_result_t r;
      r.kind = kind; r.status = st; r.key = k; r.payload = p;
      r.position = pos; r.count = cnt[5:0]; r.last = 1'b0;
      awaited.push_back(r);
    endfunction

    function void merge_batch();
      logic [31:0] nk[$];
      logic [31:0] np[$];
      logic [31:0] mk[DEPTH];
      logic [31:0] mp[DEPTH];
      bit          fresh[DEPTH];
      int          w, first, a, b, d, j;
      bit          hit, later;
      logic [1:0]  st;
      st = ST_OK;
      // removal pass in key order, with compaction
      w = 0;
      first = awaited.size();
      for (int i = 0; i < tab_cnt; i++) begin
        hit = 0;
        foreach (rem_key[q]) if (rem_key[q] == tab_key[i]) hit = 1;
        if (hit) push(KIND_REMOVED, ST_OK, tab_key[i], tab_pay[i], 5'd0, 0);
        else begin
          tab_key[w] = tab_key[i];
          tab_pay[w] = tab_pay[i];
          w++;
        end
      end
      tab_cnt = w;
      for (int i = first; i < awaited.size(); i++) awaited[i].count = tab_cnt[5:0];
      // last submission wins, keys already present are dropped
      for (int i = 0; i < ins_key.size(); i++) begin
        later = 0;
        for (int q = i + 1; q < ins_key.size(); q++) if (ins_key[q] == ins_key[i]) later = 1;
        for (int q = 0; q < tab_cnt; q++) if (tab_key[q] == ins_key[i]) later = 1;
        if (!later) begin
          j = 0;
          while (j < nk.size() && nk[j] < ins_key[i]) j++;
          nk.insert(j, ins_key[i]);
          np.insert(j, ins_pay[i]);
        end
      end
      if (tab_cnt + nk.size() > DEPTH) st = ST_OVERFLOW;
      else if (nk.size() > 0) begin
        a = 0; b = 0; d = 0;
        while (a < tab_cnt || b < nk.size()) begin
          if (b >= nk.size() || (a < tab_cnt && tab_key[a] < nk[b])) begin
            mk[d] = tab_key[a]; mp[d] = tab_pay[a]; fresh[d] = 0; a++;
          end else begin
            mk[d] = nk[b]; mp[d] = np[b]; fresh[d] = 1; b++;
          end
          d++;
        end
        tab_cnt = d;
        for (int i = 0; i < d; i++) begin
          tab_key[i] = mk[i];
          tab_pay[i] = mp[i];
          if (fresh[i]) push(KIND_INSERT, ST_OK, mk[i], mp[i], i[4:0], tab_cnt);
        end
      end
      ins_key.delete();
      ins_pay.delete();
      rem_key.delete();
      push(KIND_DONE, st, 32'd0, 32'd0, 5'd0, tab_cnt);
    endfunction

    // one accepted request beat
    function void note_request(logic [1:0] req, logic [31:0] k, logic [31:0] p,
                               logic [4:0] idx);
      case (req)
        REQ_INSERT: begin
          if (ins_key.size() < INS_DEPTH) begin
            ins_key.push_back(k);
            ins_pay.push_back(p);
            push(KIND_ACK, ST_OK, 32'd0, 32'd0, 5'd0, tab_cnt);
          end else push(KIND_ACK, ST_FULL, 32'd0, 32'd0, 5'd0, tab_cnt);
        end
        REQ_REMOVE: begin
          if (rem_key.size() < REM_DEPTH) begin
            rem_key.push_back(k);
            push(KIND_ACK, ST_OK, 32'd0, 32'd0, 5'd0, tab_cnt);
          end else push(KIND_ACK, ST_FULL, 32'd0, 32'd0, 5'd0, tab_cnt);
        end
        REQ_MAINT: merge_batch();
        default: begin
          if (idx < tab_cnt) push(KIND_READ, ST_OK, tab_key[idx], tab_pay[idx], idx, tab_cnt);
          else push(KIND_READ, ST_RANGE, 32'd0, 32'd0, 5'd0, tab_cnt);
        end
      endcase
      awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    // one accepted result beat against the oldest prediction
    function void check_result(table_result_t got);
      table_result_t exp_r;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: kind %0d", got.kind);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (got.kind !== exp_r.kind) begin
        $error("result_kind: expected %0d, got %0d", exp_r.kind, got.kind); errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status); errors++;
      end
      if (got.key !== exp_r.key) begin
        $error("key_out: expected %h, got %h", exp_r.key, got.key); errors++;
      end
      if (got.payload !== exp_r.payload) begin
        $error("payload_out: expected %h, got %h", exp_r.payload, got.payload); errors++;
      end
      if (got.position !== exp_r.position) begin
        $error("position_out: expected %0d, got %0d", exp_r.position, got.position); errors++;
      end
      if (got.count !== exp_r.count) begin
        $error("entry_count: expected %0d, got %0d", exp_r.count, got.count); errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last_result: expected %0d, got %0d", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // entity_key[31:0], payload_in[63:32], read_index[68:64]
  logic [1:0]  in_tuser = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // status, key_out, payload_out, position_out, entry_count
  logic [2:0]  out_tuser;       // result_kind[2:0]
  logic        out_tlast;

  table_scoreboard sb = new();
  logic [31:0]     key_pool[64];
  int              sent = 0;
  bit              calm = 0;       // no idling in the closing stretch
  bit              long_hold = 0;  // asks the receiver for one long stall
  int              cycles = 0;

  always #5 clk = ~clk;

  sorted_table_batched_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // result monitor
  always @(posedge clk) begin
    table_result_t r;
    if (rst_n && out_tvalid && out_tready) begin
      r.kind = out_tuser;
      r.status = out_tdata[1:0];
      r.key = out_tdata[33:2];
      r.payload = out_tdata[65:34];
      r.position = out_tdata[70:66];
      r.count = out_tdata[76:71];
      r.last = out_tlast;
      sb.check_result(r);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        for (int c = 0; c < 3000; c++) @(posedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end
    end
  end

  // cycle cap
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("sorted_table_batched_update: mismatch");
      $finish;
    end
  end

  // drives one request beat and waits for its acceptance
  task automatic send_req(logic [1:0] req, logic [31:0] k, logic [31:0] p, logic [4:0] idx);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, idx, p, k};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, k, p, idx);
    sent++;
  endtask

  function automatic logic [31:0] pick_key();
    return key_pool[$urandom_range(0, 63)];
  endfunction

  // queued inserts and removes in random order, a maintenance, then a few reads
  task automatic send_batch();
    int ni, nr, nrd;
    ni  = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 12);
    nr  = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 6);
    nrd = $urandom_range(0, 3);
    while (ni + nr > 0) begin
      if (ni > 0 && (nr == 0 || $urandom_range(0, 1))) begin
        send_req(REQ_INSERT, pick_key(), $urandom(), 5'($urandom()));
        ni--;
      end else begin
        send_req(REQ_REMOVE, pick_key(), $urandom(), 5'($urandom()));
        nr--;
      end
    end
    send_req(REQ_MAINT, $urandom(), $urandom(), 5'($urandom()));
    repeat (nrd) send_req(REQ_READ, $urandom(), $urandom(), 5'($urandom_range(0, 31)));
  endtask

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 64; i++) key_pool[i] = $urandom();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, duplicates, absent keys, out-of-range reads
    send_req(REQ_READ, 32'd0, 32'd0, 5'd0);
    send_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    send_req(REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 5'd0);
    send_req(REQ_INSERT, 32'h0000_0010, 32'h1111_1111, 5'd0);
    send_req(REQ_INSERT, 32'h0000_0010, 32'h2222_2222, 5'd0);  // later submission wins
    send_req(REQ_REMOVE, 32'h0000_0555, 32'd0, 5'd0);          // absent key
    send_req(REQ_MAINT, 32'd0, 32'd0, 5'd0);
    send_req(REQ_READ, 32'd0, 32'd0, 5'd0);
    send_req(REQ_READ, 32'd0, 32'd0, 5'd2);
    send_req(REQ_READ, 32'd0, 32'd0, 5'd3);
    send_req(REQ_READ, 32'd0, 32'd0, 5'd31);
    send_req(REQ_INSERT, 32'h0000_0010, 32'h3333_3333, 5'd0);  // already in the table
    send_req(REQ_REMOVE, 32'hFFFF_FFFF, 32'd0, 5'd0);
    send_req(REQ_REMOVE, 32'hFFFF_FFFF, 32'd0, 5'd0);          // removed only once
    send_req(REQ_REMOVE, 32'h0000_0000, 32'd0, 5'd0);
    send_req(REQ_INSERT, 32'h0000_0000, 32'hABCD_0123, 5'd0);  // removed then reinserted
    send_req(REQ_MAINT, 32'd0, 32'd0, 5'd0);
    send_req(REQ_MAINT, 32'd0, 32'd0, 5'd0);                   // empty batch
    send_req(REQ_READ, 32'd0, 32'd0, 5'd1);

    // random: mostly well-formed batches, some loose requests
    while (sent < RAND_ITEMS) begin
      if (sent > 200 && sent < 230 && !long_hold) long_hold = 1;
      if (sent > 300 && sent < 320) begin
        in_tvalid <= 1'b0;
        wait (sb.awaited.size() == 0);
        @(posedge clk);
      end
      if (sent > 400) calm = 1;
      if ($urandom_range(0, 6) != 0) send_batch();
      else send_req(2'($urandom()), ($urandom_range(0, 1) ? $urandom() : pick_key()),
                    $urandom(), 5'($urandom()));
    end
    in_tvalid <= 1'b0;

    wait (sb.awaited.size() == 0);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("sorted_table_batched_update: match");
    else $display("sorted_table_batched_update: mismatch");
    $finish;
  end

endmodule
